### rtl/lsfi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsfi_pkg;

    // Default widths of the corner values and of the fraction
    localparam int PHI_WIDTH_DEF     = 32;
    localparam int FRACTION_BITS_DEF = 16;

    // How the final stage forms the fraction
    typedef enum logic [1:0] {
        KIND_ZERO,  // no corner inside
        KIND_ONE,   // all corners inside
        KIND_TRI,   // one or two corner triangles
        KIND_TRAP   // two adjacent corners inside
    } t_kind;

    // Per-transaction control that travels beside the edge divisions
    typedef struct packed {
        t_kind      kind;
        logic       inv;    // use outside triangles and take the complement
        logic [3:0] sel;    // corners whose triangle enters the sum
        logic [3:0] efull;  // edge fully inside, or crossing at far end
        logic [3:0] ezero;  // edge has no inside part
    } t_side;

endpackage

`default_nettype wire

### rtl/lsfi_div_step.sv
`timescale 1ns / 1ps
`default_nettype none

// One registered step of a restoring fraction divider: one quotient bit.
module lsfi_div_step #(
    parameter int RW = 33,
    parameter int QW = 16
) (
    input  wire logic          i_clk,
    input  wire logic [RW-1:0] i_rem,
    input  wire logic [RW-1:0] i_den,
    input  wire logic [QW-1:0] i_quo,
    output logic      [RW-1:0] o_rem,
    output logic      [RW-1:0] o_den,
    output logic      [QW-1:0] o_quo
);

    logic [RW:0]   c_shift;
    logic          c_ge;
    logic [RW-1:0] n_rem;

    // Shift the remainder and try to subtract the divisor
    always_comb begin
        c_shift = {i_rem, 1'b0};
        c_ge    = (c_shift >= {1'b0, i_den});
        n_rem   = c_ge ? RW'(c_shift - {1'b0, i_den}) : c_shift[RW-1:0];
    end

    // Hold the step result for the next stage
    always_ff @(posedge i_clk) begin
        o_rem <= n_rem;
        o_den <= i_den;
        o_quo <= {i_quo[QW-2:0], c_ge};
    end

endmodule

`default_nettype wire

### rtl/level_set_cell_fraction_inside_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Inside area fraction of one square level-set cell.
//
// Command channel: a transaction is taken at a rising edge where i_start is
// high and o_busy is low. It carries the four signed corner values.
// Result channel: o_valid is high for exactly one cycle with the unsigned
// fraction on o_inside_fraction (2^FRACTION_BITS means the whole cell).
// The receiver cannot stall; results are never held back.
// Throughput is one cell per cycle while o_busy is low.
// Timing is set by the edge crossing divisions: a setup stage, then four
// lanes of a restoring divider, one quotient bit per register stage,
// followed by a product stage and a sum and complement stage.
// Reset clears all valid bits; transactions in flight are dropped. o_busy is
// high while reset is asserted and until the r_live register is set after it,
// and low at all other times.
module level_set_cell_fraction_inside_top #(
    parameter int PHI_WIDTH     = lsfi_pkg::PHI_WIDTH_DEF,
    parameter int FRACTION_BITS = lsfi_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    output logic                             o_busy,
    input  wire logic signed [PHI_WIDTH-1:0] i_corner_bottom_left,
    input  wire logic signed [PHI_WIDTH-1:0] i_corner_bottom_right,
    input  wire logic signed [PHI_WIDTH-1:0] i_corner_top_left,
    input  wire logic signed [PHI_WIDTH-1:0] i_corner_top_right,
    output logic                             o_valid,
    output logic [FRACTION_BITS:0]           o_inside_fraction
);

    localparam int W   = PHI_WIDTH;
    localparam int FB  = FRACTION_BITS;
    localparam int RW  = W + 1;
    localparam int PW  = 2 * FB + 2;
    localparam int SW  = 2 * FB + 4;
    localparam int LAT = FB + 3;
    localparam logic [FB:0] FULL = {1'b1, {FB{1'b0}}};

    logic r_live;
    logic c_accept;

    // Hold busy during reset and until r_live is set after it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else begin
            r_live <= 1'b1;
        end
    end

    assign o_busy   = !r_live || !i_rst_n;
    assign c_accept = i_start && !o_busy;

    // ---------------- setup stage ----------------
    logic [W-1:0]       c_phi [4];
    logic [3:0]         c_in;
    logic [W-1:0]       c_mag [4];
    logic signed [W+1:0] c_total;
    logic [2:0]         c_cnt;
    logic               c_diag;
    lsfi_pkg::t_side    c_side;
    logic [RW-1:0]      c_rem [4];
    logic [RW-1:0]      c_den [4];

    // Cyclic corner order: bottom left, bottom right, top right, top left
    assign c_phi[0] = i_corner_bottom_left;
    assign c_phi[1] = i_corner_bottom_right;
    assign c_phi[2] = i_corner_top_right;
    assign c_phi[3] = i_corner_top_left;

    // Classify corners and set up one crossing division per edge
    always_comb begin
        logic [W-1:0] num;
        logic [W-1:0] oth;
        logic         ci;
        logic         cj;
        c_total = '0;
        c_cnt   = 3'd0;
        for (int k = 0; k < 4; k++) begin
            c_in[k]  = c_phi[k][W-1];
            c_mag[k] = c_in[k] ? W'(~c_phi[k] + 1'b1) : c_phi[k];
            c_total  = c_total + $signed({{2{c_phi[k][W-1]}}, c_phi[k]});
            c_cnt    = c_cnt + {2'b00, c_in[k]};
        end
        c_diag     = (c_cnt == 3'd2) && (c_in[0] == c_in[2]);
        c_side.inv = (c_cnt == 3'd3) || (c_diag && c_total[W+1]);
        priority if (c_cnt == 3'd4) begin
            c_side.kind = lsfi_pkg::KIND_ONE;
        end else if (c_cnt == 3'd0) begin
            c_side.kind = lsfi_pkg::KIND_ZERO;
        end else if ((c_cnt == 3'd2) && !c_diag) begin
            c_side.kind = lsfi_pkg::KIND_TRAP;
        end else begin
            c_side.kind = lsfi_pkg::KIND_TRI;
        end
        for (int k = 0; k < 4; k++) begin
            c_side.sel[k] = c_side.inv ? !c_in[k] : c_in[k];
            ci  = c_in[k];
            cj  = c_in[2'(k + 1)];
            num = ci ? c_mag[k] : c_mag[2'(k + 1)];
            oth = ci ? c_mag[2'(k + 1)] : c_mag[k];
            c_side.efull[k] = (ci && cj) || ((ci ^ cj) && (oth == '0));
            c_side.ezero[k] = !ci && !cj;
            c_rem[k] = (ci ^ cj) ? {1'b0, num} : '0;
            c_den[k] = (ci ^ cj) ? ({1'b0, num} + {1'b0, oth}) : RW'(1);
        end
    end

    logic            r_a_vld;
    lsfi_pkg::t_side r_a_side;
    logic [RW-1:0]   r_a_rem [4];
    logic [RW-1:0]   r_a_den [4];

    // Hold setup results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= c_accept;
        end
        r_a_side <= c_side;
        r_a_rem  <= c_rem;
        r_a_den  <= c_den;
    end

    // ---------------- divider stages ----------------
    logic [RW-1:0] s_rem [FB+1][4];
    logic [RW-1:0] s_den [FB+1][4];
    logic [FB-1:0] s_quo [FB+1][4];

    for (genvar k = 0; k < 4; k++) begin : g_lane_in
        assign s_rem[0][k] = r_a_rem[k];
        assign s_den[0][k] = r_a_den[k];
        assign s_quo[0][k] = '0;
    end

    for (genvar j = 0; j < FB; j++) begin : g_step
        for (genvar k = 0; k < 4; k++) begin : g_lane
            lsfi_div_step #(
                .RW(RW),
                .QW(FB)
            ) u_step (
                .i_clk(i_clk),
                .i_rem(s_rem[j][k]),
                .i_den(s_den[j][k]),
                .i_quo(s_quo[j][k]),
                .o_rem(s_rem[j+1][k]),
                .o_den(s_den[j+1][k]),
                .o_quo(s_quo[j+1][k])
            );
        end
    end

    logic [FB-1:0]   r_vp;
    lsfi_pkg::t_side r_sp [FB];

    // Advance control beside the divider lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= '0;
        end else begin
            r_vp <= {r_vp[FB-2:0], r_a_vld};
        end
        r_sp[0] <= r_a_side;
        for (int j = 1; j < FB; j++) begin
            r_sp[j] <= r_sp[j-1];
        end
    end

    // ---------------- product stage ----------------
    lsfi_pkg::t_side c_ms;
    logic [FB:0]     c_e [4];
    logic [FB:0]     c_x [4];
    logic [FB+2:0]   c_esum;
    logic [PW-1:0]   c_prod [4];

    // Form edge fractions and the corner triangle products
    always_comb begin
        c_ms   = r_sp[FB-1];
        c_esum = '0;
        for (int k = 0; k < 4; k++) begin
            if (c_ms.efull[k]) begin
                c_e[k] = FULL;
            end else if (c_ms.ezero[k]) begin
                c_e[k] = '0;
            end else begin
                c_e[k] = {1'b0, s_quo[FB][k]};
            end
            c_x[k] = c_ms.inv ? FULL - c_e[k] : c_e[k];
            c_esum = c_esum + {2'b00, c_e[k]};
        end
        for (int k = 0; k < 4; k++) begin
            c_prod[k] = c_ms.sel[k]
                ? {{(FB+1){1'b0}}, c_x[2'(k + 3)]} * {{(FB+1){1'b0}}, c_x[k]}
                : '0;
        end
    end

    logic            r_m_vld;
    lsfi_pkg::t_kind r_m_kind;
    logic            r_m_inv;
    logic [PW-1:0]   r_m_prod [4];
    logic [FB:0]     r_m_trap;
    logic [FB+2:0]   c_trap2;

    // Adjacent pair: one edge fully inside, one empty, two crossings
    assign c_trap2 = c_esum - {2'b00, FULL};

    // Hold products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else begin
            r_m_vld <= r_vp[FB-1];
        end
        r_m_kind <= c_ms.kind;
        r_m_inv  <= c_ms.inv;
        r_m_prod <= c_prod;
        r_m_trap <= c_trap2[FB+1:1];
    end

    // ---------------- final stage ----------------
    logic [SW-1:0] c_psum;
    logic [FB:0]   c_tri;
    logic [FB:0]   n_frac;

    // Sum and halve the triangles, complement if inv; or take zero, one, trap
    always_comb begin
        c_psum = '0;
        for (int k = 0; k < 4; k++) begin
            c_psum = c_psum + {2'b00, r_m_prod[k]};
        end
        c_tri = c_psum[2*FB+1:FB+1];
        unique case (r_m_kind)
            lsfi_pkg::KIND_ZERO: n_frac = '0;
            lsfi_pkg::KIND_ONE:  n_frac = FULL;
            lsfi_pkg::KIND_TRAP: n_frac = r_m_trap;
            lsfi_pkg::KIND_TRI:  n_frac = r_m_inv ? FULL - c_tri : c_tri;
            default:             n_frac = '0;
        endcase
    end

    logic        r_o_vld;
    logic [FB:0] r_o_frac;

    // Drive the result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_m_vld;
        end
        r_o_frac <= n_frac;
    end

    assign o_valid           = r_o_vld;
    assign o_inside_fraction = r_o_frac;

`ifndef SYNTH
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_inside_fraction <= FULL))
        else $error("fraction above one");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

    a_all_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_accept && (c_in == 4'hf)) |-> ##LAT (o_valid && (o_inside_fraction == FULL)))
        else $error("all-inside cell not full");

    a_all_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_accept && (c_in == 4'h0)) |-> ##LAT (o_valid && (o_inside_fraction == '0)))
        else $error("all-outside cell not empty");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_accept |-> ##LAT o_valid)
        else $error("result missing after accept");
`endif

endmodule

`default_nettype wire

### tb/sv/level_set_cell_fraction_inside_top_tb.sv
`timescale 1ns / 1ps

module level_set_cell_fraction_inside_top_tb;

    localparam int PW      = lsfi_pkg::PHI_WIDTH_DEF;
    localparam int FB      = lsfi_pkg::FRACTION_BITS_DEF;
    localparam int LATENCY = FB + 3;
    localparam longint FULL_ONE = longint'(1) << FB;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic signed [PW-1:0] t_phi;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_start = 1'b0;
    logic            o_busy;
    t_phi            i_corner_bottom_left = '0;
    t_phi            i_corner_bottom_right = '0;
    t_phi            i_corner_top_left = '0;
    t_phi            i_corner_top_right = '0;
    logic            o_valid;
    logic [FB:0]     o_inside_fraction;

    logic [FB:0]     fraction_queue[$];
    int              error_count = 0;
    int              cells_sent = 0;
    int              fractions_seen = 0;
    longint          cycle_count = 0;

    // Corner state of the cell being predicted, cyclic order BL, BR, TR, TL
    bit              cin[4];
    longint          cmag[4];

    level_set_cell_fraction_inside_top i_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_start               (i_start),
        .o_busy                (o_busy),
        .i_corner_bottom_left  (i_corner_bottom_left),
        .i_corner_bottom_right (i_corner_bottom_right),
        .i_corner_top_left     (i_corner_top_left),
        .i_corner_top_right    (i_corner_top_right),
        .o_valid               (o_valid),
        .o_inside_fraction     (o_inside_fraction)
    );

    always #2 i_clk = ~i_clk;

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Floor of num * 2^FB / den, full edge when num reaches den
    function automatic longint crossing_div(longint num, longint den);
        if (den == 0 || num >= den) return FULL_ONE;
        return (num << FB) / den;
    endfunction

    function automatic longint edge_part(int i, int j);
        int a;
        int b;
        a = i & 3;
        b = j & 3;
        if (cin[a] && cin[b]) return FULL_ONE;
        if (cin[a]) return crossing_div(cmag[a], cmag[a] + cmag[b]);
        if (cin[b]) return crossing_div(cmag[b], cmag[a] + cmag[b]);
        return 0;
    endfunction

    function automatic logic [FB:0] cell_fraction(t_phi bl, t_phi br, t_phi tl, t_phi tr);
        t_phi   c[4];
        int     cnt;
        int     s;
        longint total;
        longint r;
        longint a0, a1, a2, a3;
        c = '{bl, br, tr, tl};
        cnt = 0;
        s = 0;
        total = 0;
        r = 0;
        for (int k = 0; k < 4; k++) begin
            cin[k] = c[k][PW-1];
            cmag[k] = cin[k] ? -longint'(c[k]) : longint'(c[k]);
            total += longint'(c[k]);
            if (cin[k]) cnt++;
        end
        if (cnt == 4) begin
            r = FULL_ONE;
        end else if (cnt == 0) begin
            r = 0;
        end else if (cnt == 1 || cnt == 3) begin
            for (int k = 3; k >= 0; k--)
                if (cin[k] == (cnt == 1)) s = k;
            if (cnt == 1) begin
                r = (edge_part(s, s + 3) * edge_part(s, s + 1)) >> (FB + 1);
            end else begin
                a0 = FULL_ONE - edge_part(s, s + 3);
                a1 = FULL_ONE - edge_part(s, s + 1);
                r = FULL_ONE - ((a0 * a1) >> (FB + 1));
            end
        end else begin
            for (int k = 3; k >= 0; k--)
                if (cin[k] && (cin[(k + 1) & 3] || cin[(k + 2) & 3])) s = k;
            if (cin[(s + 1) & 3]) begin
                r = (edge_part(s, s + 3) + edge_part(s + 1, s + 2)) >> 1;
            end else if (total < 0) begin
                a1 = FULL_ONE - edge_part(s, s + 3);
                a3 = FULL_ONE - edge_part(s + 2, s + 3);
                a2 = FULL_ONE - edge_part(s + 2, s + 1);
                a0 = FULL_ONE - edge_part(s, s + 1);
                r = FULL_ONE - ((a1 * a3 + a0 * a2) >> (FB + 1));
            end else begin
                r = (edge_part(s, s + 1) * edge_part(s, s + 3)
                     + edge_part(s + 2, s + 1) * edge_part(s + 2, s + 3)) >> (FB + 1);
            end
        end
        if (r > FULL_ONE) r = FULL_ONE;
        return r[FB:0];
    endfunction

    // Compare each result against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            fractions_seen++;
            if (fraction_queue.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $realtime, o_inside_fraction);
                error_count++;
            end else begin
                if (o_inside_fraction !== fraction_queue[0]) begin
                    $display("%0t: inside_fraction mismatch, expected %0d, actual %0d",
                             $realtime, fraction_queue[0], o_inside_fraction);
                    error_count++;
                end
                void'(fraction_queue.pop_front());
            end
        end
    end

    // Mostly short gaps, now and then a long one
    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 9);
        if (n < 5) n = 0;
        else if (n < 9) n = $urandom_range(1, 3);
        else n = $urandom_range(5, 30);
        if (n > 0) begin
            i_start <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Hold one transaction until the block accepts it
    task automatic send_cell(t_phi bl, t_phi br, t_phi tl, t_phi tr, bit gaps);
        i_corner_bottom_left  <= bl;
        i_corner_bottom_right <= br;
        i_corner_top_left     <= tl;
        i_corner_top_right    <= tr;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        fraction_queue.push_back(cell_fraction(bl, br, tl, tr));
        cells_sent++;
        @(negedge i_clk);
        if (gaps && $urandom_range(0, 3) == 0) begin
            idle_gap();
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (fraction_queue.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_phi rand_phi();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return t_phi'({1'b1, {(PW-1){1'b0}}});
            1: return t_phi'({1'b0, {(PW-1){1'b1}}});
            2: return '0;
            3: return t_phi'($urandom_range(0, 8)) - 4;
            4, 5: return t_phi'($urandom_range(0, 2 ** 18)) - t_phi'(2 ** 17);
            default: return t_phi'($urandom());
        endcase
    endfunction

    task automatic test_directed();
        t_phi mn;
        t_phi mx;
        t_phi one;
        mn = t_phi'({1'b1, {(PW-1){1'b0}}});
        mx = t_phi'({1'b0, {(PW-1){1'b1}}});
        one = t_phi'(FULL_ONE);
        send_cell(one, one, one, one, 0);
        send_cell(-one, -one, -one, -one, 0);
        send_cell(0, 0, 0, 0, 0);
        send_cell(mn, mn, mn, mn, 0);
        send_cell(mx, mx, mx, mx, 0);
        send_cell(-one, one, one, one, 0);
        send_cell(one, -one, one, one, 0);
        send_cell(one, one, -one, one, 0);
        send_cell(one, one, one, -one, 0);
        send_cell(one, -one, -one, -one, 0);
        send_cell(-one, -one, 0, 0, 0);
        send_cell(-one, 0, -one, 0, 0);
        send_cell(-one, one, one, -one, 0);
        send_cell(one, -one, -one, one, 0);
        send_cell(-one, 2 * one, 2 * one, -one, 0);
        send_cell(-2 * one, one, one, -2 * one, 0);
        send_cell(-1, 0, 0, 0, 0);
        send_cell(mn, mx, mx, mn, 0);
        send_cell(mn, mx, mx, mx, 0);
        send_cell(mx, mn, mn, mn, 0);
        send_cell(mn, 1, 1, 1, 0);
        send_cell(-1, mx, mx, mx, 0);
        drain();
    endtask

    task automatic test_random(int n);
        for (int k = 0; k < n; k++) begin
            send_cell(rand_phi(), rand_phi(), rand_phi(), rand_phi(), 1);
            // Pause until every outstanding result has come back
            if (k == n / 2) drain();
        end
        drain();
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(1700);
        repeat (LATENCY + 4) @(negedge i_clk);
        $display("Sent %0d cells (extremes, zero corners, diagonal ties, random mix);",
                 cells_sent);
        $display("checked %0d fractions with random sender gaps.", fractions_seen);
        if (error_count == 0 && fraction_queue.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
